>>> rtl/iirdf1_pkg.sv
package iirdf1_pkg;

  // Fixed field widths of the stream items
  localparam int FUNC_W   = 2;
  localparam int SAMPLE_W = 24;
  localparam int CIDX_W   = 5;
  localparam int COEF_W   = 32;
  localparam int CFG_W    = 4;

  // Defaults for the top-level parameters
  localparam int ORDER_MAX_DEF      = 8;
  localparam int COEF_FRAC_BITS_DEF = 28;

  // Filter order after reset
  localparam logic [CFG_W-1:0] ORDER_RST = CFG_W'(2);

  // Output clip limits
  localparam int SMP_MAX = 8388607;
  localparam int SMP_MIN = -8388608;

  // Product of one coefficient and one sample
  localparam int PROD_W = COEF_W + SAMPLE_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_SAMPLE = 2'd0,
    FN_LOAD   = 2'd1,
    FN_CLEAR  = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

>>> rtl/iirdf1_ram.sv
module iirdf1_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/iir_direct_form_one_filter_core.sv
// Direct form I IIR filter, programmable order, one shared multiply-accumulate.
//
// Input stream (in_*): in_tuser carries the function code (0 filter a sample,
// 1 load a coefficient, 2 clear the sample histories, 3 ignored). Only a
// sample transaction produces a result on the output stream (out_*): the
// rounded, clipped sample in out_tdata and the clip flag in out_tuser.
// cfg_we/cfg_wdata set the filter order N; write it only while idle.
//
// Sequencing: load, clear and unused codes complete on acceptance. A sample
// walks the 2N+1 taps through one 32x24 multiplier, one tap per cycle, fed
// from the coefficient RAM's single read port: an accept step, the issue of
// every tap, the drain of the operand and product stages, then a finish
// step; the result shows on out_tvalid the cycle after finish.
// in_tready is high only while the sequencer is idle.
//
// Reset (rst_n low, synchronous) zeros the histories, marks every
// coefficient as zero through per-entry valid bits and sets N to 2.
// A stalled receiver holds the result in the output register; the next
// sample computes but waits in its finish step until that register frees.
module iir_direct_form_one_filter_core #(
  parameter int ORDER_MAX      = iirdf1_pkg::ORDER_MAX_DEF,
  parameter int COEF_FRAC_BITS = iirdf1_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // config: filter_order[3:0]
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  // in_tdata: sample_in[23:0], coef_index[28:24], coef_value[60:29], zero pad
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,
  // in_tuser: func[1:0]
  input  logic [1:0]  in_tuser,
  // out_tdata: sample_out[23:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // out_tuser: saturated[0]
  output logic        out_tuser
);
  import iirdf1_pkg::*;

  localparam int TABLE_SIZE = 2 * ORDER_MAX + 1;
  localparam int TAP_W      = $clog2(TABLE_SIZE);
  localparam int HIST_AW    = (ORDER_MAX > 1) ? $clog2(ORDER_MAX) : 1;
  localparam int ACC_W      = PROD_W + TAP_W + 1;
  localparam int NW         = ((TAP_W > CFG_W) ? TAP_W : CFG_W) + 1;
  localparam int IW         = ((TAP_W > CIDX_W) ? TAP_W : CIDX_W) + 1;

  localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] YMAX = ACC_W'(SMP_MAX);
  localparam logic signed [ACC_W-1:0] YMIN = ACC_W'(SMP_MIN);

  // ---------------- input unpack ----------------
  func_t                     in_func;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [CIDX_W-1:0]          in_cidx;
  logic signed [COEF_W-1:0]   in_coef;
  logic                       in_acc;

  assign in_func   = func_t'(in_tuser);
  assign in_sample = $signed(in_tdata[23:0]);
  assign in_cidx   = in_tdata[28:24];
  assign in_coef   = $signed(in_tdata[60:29]);
  assign in_acc    = in_tvalid && in_tready;

  // ---------------- state ----------------
  state_t state_r, state_nxt;
  logic [CFG_W-1:0]           order_r;
  logic [TAP_W-1:0]           tap_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] xh_r [ORDER_MAX];
  logic signed [SAMPLE_W-1:0] yh_r [ORDER_MAX];
  logic [TABLE_SIZE-1:0]      cvld_r;

  // MAC pipeline: stage 1 holds operands, stage 2 the product
  logic                       v1_r, v2_r;
  logic                       sub1_r, sub2_r;
  logic                       cvq_r;
  logic signed [SAMPLE_W-1:0] opnd_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r;

  logic                       out_tvalid_r;
  logic [SAMPLE_W-1:0]        out_tdata_r;
  logic                       out_tuser_r;

  // ---------------- effective order ----------------
  logic [NW-1:0]    n_eff;
  logic [TAP_W-1:0] last_tap;

  always_comb begin
    n_eff = NW'(order_r);
    if (n_eff == '0) begin
      n_eff = NW'(1);
    end else if (n_eff > NW'(ORDER_MAX)) begin
      n_eff = NW'(ORDER_MAX);
    end
  end
  assign last_tap = TAP_W'(n_eff << 1);

  // ---------------- tap decode ----------------
  // tap 0: b0*x; odd tap 2k-1: b_k*x[n-k]; even tap 2k: a_k*y[n-k]
  logic [TAP_W:0]     tap_p1;
  logic [TAP_W-1:0]   tap_k;
  logic               tap_a;
  logic [TAP_W-1:0]   rd_addr;
  logic [HIST_AW-1:0] hidx;

  assign tap_p1  = (TAP_W+1)'(tap_r) + (TAP_W+1)'(1);
  assign tap_k   = tap_p1[TAP_W:1];
  assign tap_a   = (tap_r != '0) && !tap_r[0];
  assign rd_addr = tap_a ? TAP_W'(ORDER_MAX) + tap_k : tap_k;
  assign hidx    = HIST_AW'(tap_k - TAP_W'(1));

  // ---------------- coefficient table ----------------
  logic              cwr_en;
  logic [TAP_W-1:0]  cwr_addr;
  logic [COEF_W-1:0] ram_q;
  logic signed [COEF_W-1:0] coef_op;

  assign cwr_en   = in_acc && (in_func == FN_LOAD) && (IW'(in_cidx) < IW'(TABLE_SIZE));
  assign cwr_addr = TAP_W'(in_cidx);

  iirdf1_ram #(
    .WIDTH (COEF_W),
    .DEPTH (TABLE_SIZE)
  ) u_coef_ram (
    .clk   (clk),
    .we    (cwr_en),
    .waddr (cwr_addr),
    .wdata (in_coef),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // never-written entries read as zero
  assign coef_op = cvq_r ? $signed(ram_q) : '0;

  // ---------------- sequencer ----------------
  logic issue;
  logic out_free;
  logic finish;

  assign out_free = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_func == FN_SAMPLE) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (tap_r == last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    finish    = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_MAC:   issue     = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  finish    = out_free;
      default:  ;
    endcase
  end

  // ---------------- round and clip ----------------
  logic signed [ACC_W-1:0]    y_sh;
  logic                       y_hi, y_lo;
  logic signed [SAMPLE_W-1:0] y_sat;

  assign y_sh = acc_r >>> COEF_FRAC_BITS;
  assign y_hi = y_sh > YMAX;
  assign y_lo = y_sh < YMIN;

  always_comb begin
    priority if (y_hi) begin
      y_sat = SAMPLE_W'(SMP_MAX);
    end else if (y_lo) begin
      y_sat = SAMPLE_W'(SMP_MIN);
    end else begin
      y_sat = y_sh[SAMPLE_W-1:0];
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      order_r      <= ORDER_RST;
      cvld_r       <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
      tap_r        <= '0;
      for (int i = 0; i < ORDER_MAX; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
      if (cwr_en) begin
        cvld_r[cwr_addr] <= 1'b1;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      tap_r <= issue ? tap_r + TAP_W'(1) : '0;

      if (finish) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end

      if (in_acc && in_func == FN_CLEAR) begin
        for (int i = 0; i < ORDER_MAX; i++) begin
          xh_r[i] <= '0;
          yh_r[i] <= '0;
        end
      end else if (finish) begin
        for (int i = 1; i < ORDER_MAX; i++) begin
          xh_r[i] <= xh_r[i-1];
          yh_r[i] <= yh_r[i-1];
        end
        xh_r[0] <= x_r;
        yh_r[0] <= y_sat;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (in_acc && in_func == FN_SAMPLE) begin
      x_r <= in_sample;
    end
    // stage 1: operand select, aligned with the RAM read
    cvq_r  <= cvld_r[rd_addr];
    sub1_r <= tap_a;
    if (tap_r == '0) begin
      opnd_r <= x_r;
    end else if (tap_a) begin
      opnd_r <= yh_r[hidx];
    end else begin
      opnd_r <= xh_r[hidx];
    end
    // stage 2: product
    prod_r <= coef_op * opnd_r;
    sub2_r <= sub1_r;
    // accumulate; start from the rounding offset
    if (in_acc && in_func == FN_SAMPLE) begin
      acc_r <= RND;
    end else if (v2_r) begin
      acc_r <= sub2_r ? acc_r - ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);
    end
    if (finish) begin
      out_tdata_r <= y_sat;
      out_tuser_r <= y_hi || y_lo;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTH
  // a sample transaction always starts a MAC pass
  a_start_mac: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_func == FN_SAMPLE) |=> (state_r == ST_MAC))
    else $error("sample accepted without starting MAC pass");

  // tap counter stays within the last tap of the effective order
  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (tap_r <= last_tap))
    else $error("tap counter past last tap");

  // finish only after the MAC pipeline has emptied
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (!v1_r && !v2_r))
    else $error("finish with products still in flight");

  // pipeline activity only inside a sample pass
  a_pipe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (state_r == ST_DRAIN || state_r == ST_MAC))
    else $error("MAC pipeline active outside a pass");
`endif

endmodule
